// File: hw/rtl/tcl_pkg.sv
// Package with the shared constants and types of the trace cache.
package tcl_pkg;

	localparam int NUM_SETS  = 64;
	localparam int WAYS      = 4;
	localparam int NUM_LINES = NUM_SETS * WAYS;
	localparam int SET_W     = $clog2(NUM_SETS);
	localparam int WAY_W     = $clog2(WAYS);
	localparam int IDX_W     = $clog2(NUM_LINES);
	localparam int ADDR_W    = 32;
	localparam int LEN_W     = 7;
	localparam int CNT_W     = 32;
	localparam int LFSR_W    = 16;

	localparam logic [LEN_W-1:0]  LEN_RESET  = LEN_W'(16);
	localparam logic [LEN_W-1:0]  LEN_MAX    = {LEN_W{1'b1}};
	localparam logic [LFSR_W-1:0] LFSR_SEED  = 16'hACE1;

	typedef struct packed {
		logic [ADDR_W-1:0] tag;
		logic              pred;
		logic [LEN_W-1:0]  len;
	} line_t;

	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] idx;
		line_t            line;
	} line_wr_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_FLUSH,
		S_READ,
		S_CMP,
		S_LIMIT,
		S_DONE
	} state_t;

endpackage

// File: hw/rtl/tcl_line_store.sv
// Line storage of the trace cache: tag memory with per-line valid bits.
module tcl_line_store (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  tcl_pkg::line_wr_t                    wr,
	input  logic                                 rd_en,
	input  logic [tcl_pkg::IDX_W-1:0]            rd_idx,
	output tcl_pkg::line_t                       rd_line,
	input  logic [tcl_pkg::SET_W-1:0]            set_idx,
	output logic [tcl_pkg::WAYS-1:0]             set_valid
);

	tcl_pkg::line_t                   mem [tcl_pkg::NUM_LINES];
	tcl_pkg::line_t                   rd_q;
	logic [tcl_pkg::NUM_LINES-1:0]    valid_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.idx] <= wr.line;
		end
		if (rd_en) begin
			rd_q <= mem[rd_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr.en) begin
			valid_q[wr.idx] <= 1'b1;
		end
	end

	always_comb begin
		for (int w = 0; w < tcl_pkg::WAYS; w++) begin
			set_valid[w] = valid_q[{set_idx, tcl_pkg::WAY_W'(w)}];
		end
	end

	assign rd_line = rd_q;

endmodule

// File: hw/rtl/trace_cache_lookup_and_fill.sv
// Top level of the trace cache: lookup sequencer, trace builder and counters.
// A fetch is taken when start is high and busy is low; its result strobes on done.
// A non-branch fetch goes to DONE, through LIMIT while a trace is being built; a branch fetch
// first stores any trace in progress, then reads and compares: one shared tag compare walks the set a way at a time.
// busy drops the cycle after done, so a new fetch is taken only once the last one is done.
// Results cannot be stalled; reset clears all valid bits and counters at once.
module trace_cache_lookup_and_fill (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [tcl_pkg::ADDR_W-1:0]        fetch_addr,
	input  logic                              is_cond_branch,
	input  logic                              branch_pred,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [tcl_pkg::LEN_W-1:0]         cfg_data,
	output logic                              done,
	output logic                              looked_up,
	output logic                              hit,
	output logic                              trace_stored,
	output logic                              building,
	output logic [tcl_pkg::CNT_W-1:0]         hit_total,
	output logic [tcl_pkg::CNT_W-1:0]         miss_total
);

	tcl_pkg::state_t                  state_q;
	tcl_pkg::state_t                  state_d;

	logic [tcl_pkg::ADDR_W-1:0]       addr_q;
	logic                             pred_q;

	logic [tcl_pkg::LEN_W-1:0]        max_len_q;
	logic [tcl_pkg::ADDR_W-1:0]       build_tag_q;
	logic                             build_pred_q;
	logic [tcl_pkg::LEN_W-1:0]        build_len_q;
	logic                             build_active_q;
	logic [tcl_pkg::IDX_W-1:0]        build_slot_q;
	logic [tcl_pkg::CNT_W-1:0]        hit_cnt_q;
	logic [tcl_pkg::CNT_W-1:0]        miss_cnt_q;
	logic [tcl_pkg::LFSR_W-1:0]       lfsr_q;
	logic [tcl_pkg::WAY_W-1:0]        way_q;
	logic                             looked_q;
	logic                             hit_q;
	logic                             stored_q;

	tcl_pkg::line_wr_t                wr;
	tcl_pkg::line_t                   rd_line;
	logic                             rd_en;
	logic [tcl_pkg::WAYS-1:0]         set_valid;
	logic [tcl_pkg::SET_W-1:0]        set_idx;
	logic                             accept;
	logic                             match;
	logic                             last_way;
	logic                             limit_hit;
	logic [tcl_pkg::LFSR_W-1:0]       lfsr_nxt;
	logic                             any_free;
	logic [tcl_pkg::WAY_W-1:0]        free_way;
	logic [tcl_pkg::WAY_W-1:0]        victim_way;

	function automatic logic [tcl_pkg::LFSR_W-1:0] lfsr_step(
		input logic [tcl_pkg::LFSR_W-1:0] v
	);
		logic fb;
		fb = v[0] ^ v[2] ^ v[3] ^ v[5];
		return {fb, v[tcl_pkg::LFSR_W-1:1]};
	endfunction

	assign accept    = start && (state_q == tcl_pkg::S_IDLE);
	assign busy      = (state_q != tcl_pkg::S_IDLE);
	assign cfg_ready = 1'b1;
	assign set_idx   = addr_q[tcl_pkg::SET_W-1:0];
	assign rd_en     = (state_q == tcl_pkg::S_READ);
	assign match     = set_valid[way_q] && (rd_line.tag == addr_q) && (rd_line.pred == pred_q);
	assign last_way  = (way_q == tcl_pkg::WAY_W'(tcl_pkg::WAYS - 1));
	assign limit_hit = (build_len_q >= max_len_q);
	assign lfsr_nxt  = lfsr_step(lfsr_q);

	always_comb begin
		any_free = 1'b0;
		free_way = '0;
		for (int w = tcl_pkg::WAYS - 1; w >= 0; w--) begin
			if (!set_valid[w]) begin
				any_free = 1'b1;
				free_way = tcl_pkg::WAY_W'(w);
			end
		end
		victim_way = any_free ? free_way : lfsr_nxt[tcl_pkg::WAY_W-1:0];
	end

	always_comb begin
		wr.en        = (state_q == tcl_pkg::S_FLUSH) ||
		               ((state_q == tcl_pkg::S_LIMIT) && limit_hit);
		wr.idx       = build_slot_q;
		wr.line.tag  = build_tag_q;
		wr.line.pred = build_pred_q;
		wr.line.len  = build_len_q;
	end

	tcl_line_store u_store (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr        (wr),
		.rd_en     (rd_en),
		.rd_idx    ({set_idx, way_q}),
		.rd_line   (rd_line),
		.set_idx   (set_idx),
		.set_valid (set_valid)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tcl_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			tcl_pkg::S_IDLE: begin
				if (start) begin
					if (is_cond_branch) begin
						state_d = build_active_q ? tcl_pkg::S_FLUSH : tcl_pkg::S_READ;
					end else begin
						state_d = build_active_q ? tcl_pkg::S_LIMIT : tcl_pkg::S_DONE;
					end
				end
			end
			tcl_pkg::S_FLUSH: state_d = tcl_pkg::S_READ;
			tcl_pkg::S_READ:  state_d = tcl_pkg::S_CMP;
			tcl_pkg::S_CMP: begin
				if (match) begin
					state_d = tcl_pkg::S_DONE;
				end else if (last_way) begin
					state_d = tcl_pkg::S_LIMIT;
				end else begin
					state_d = tcl_pkg::S_READ;
				end
			end
			tcl_pkg::S_LIMIT: state_d = tcl_pkg::S_DONE;
			tcl_pkg::S_DONE:  state_d = tcl_pkg::S_IDLE;
			default:          state_d = tcl_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			addr_q <= fetch_addr;
			pred_q <= branch_pred;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q      <= tcl_pkg::LEN_RESET;
			build_tag_q    <= '0;
			build_pred_q   <= 1'b0;
			build_len_q    <= '0;
			build_active_q <= 1'b0;
			build_slot_q   <= '0;
			hit_cnt_q      <= '0;
			miss_cnt_q     <= '0;
			lfsr_q         <= tcl_pkg::LFSR_SEED;
			way_q          <= '0;
			looked_q       <= 1'b0;
			hit_q          <= 1'b0;
			stored_q       <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				max_len_q <= cfg_data;
			end
			case (state_q)
				tcl_pkg::S_IDLE: begin
					if (start) begin
						looked_q <= is_cond_branch;
						hit_q    <= 1'b0;
						stored_q <= 1'b0;
						way_q    <= '0;
						if (!is_cond_branch && build_active_q &&
						    (build_len_q != tcl_pkg::LEN_MAX)) begin
							build_len_q <= build_len_q + 1'b1;
						end
					end
				end
				tcl_pkg::S_FLUSH: begin
					stored_q       <= 1'b1;
					build_tag_q    <= '0;
					build_pred_q   <= 1'b0;
					build_len_q    <= '0;
					build_active_q <= 1'b0;
					build_slot_q   <= '0;
				end
				tcl_pkg::S_CMP: begin
					if (match) begin
						hit_q     <= 1'b1;
						hit_cnt_q <= hit_cnt_q + 1'b1;
					end else if (last_way) begin
						miss_cnt_q     <= miss_cnt_q + 1'b1;
						build_slot_q   <= {set_idx, victim_way};
						build_tag_q    <= addr_q;
						build_pred_q   <= pred_q;
						build_len_q    <= tcl_pkg::LEN_W'(1);
						build_active_q <= 1'b1;
						if (!any_free) begin
							lfsr_q <= lfsr_nxt;
						end
					end else begin
						way_q <= way_q + 1'b1;
					end
				end
				tcl_pkg::S_LIMIT: begin
					if (limit_hit) begin
						stored_q       <= 1'b1;
						build_tag_q    <= '0;
						build_pred_q   <= 1'b0;
						build_len_q    <= '0;
						build_active_q <= 1'b0;
						build_slot_q   <= '0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign done         = (state_q == tcl_pkg::S_DONE);
	assign looked_up    = looked_q;
	assign hit          = hit_q;
	assign trace_stored = stored_q;
	assign building     = build_active_q;
	assign hit_total    = hit_cnt_q;
	assign miss_total   = miss_cnt_q;

`ifndef SYNTHESIS
	// A search result can only come from a branch fetch.
	assert property (@(posedge clk) disable iff (!arst_n) done && hit |-> looked_up)
		else $error("hit reported without a lookup");
	// Every accepted request makes the block busy on the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n) start && !busy |=> busy)
		else $error("accepted request did not raise busy");
	// The result strobe lasts one cycle and the block is idle right after.
	assert property (@(posedge clk) disable iff (!arst_n) done |=> !done && !busy)
		else $error("result strobe not followed by idle");
	// A hit never changes the miss count.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == tcl_pkg::S_CMP) && match |=> $stable(miss_cnt_q))
		else $error("miss count moved on a hit");
`endif

endmodule
